FILE: rtl/smb_pkg.sv
`timescale 1ns / 1ps

package smb_pkg;

   // Default number of timestamps kept in the window.
   localparam int WINDOW_SIZE_DEF = 11;

   localparam int TIME_W      = 32;
   localparam int USED_W      = 4;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RANK,
      ST_PICK
   } state_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic insert;
      logic step;
   } cell_ctrl_type;

endpackage

FILE: rtl/sliding_median_of_block_times.sv
`timescale 1ns / 1ps

// Channel   Dir  Bits                      Contents
// req_      in   tdata[31:0], tuser[0]     block_time, chain_start
// rsp_      out  tdata[39:0]               median_time, times_used, zero pad
//
// Each request passes from acceptance to a result in the output register by
// insertion, probe rotation around the ring of cells, and selection of the
// median.
// The rotation length is set by the number of cells the probes must visit.
// Reset (synchronous, active high) empties the window and drops any result.
// A result that is not taken holds in the output register; the next request
// is still accepted and its selection waits until that register is free.
module sliding_median_of_block_times #(
   parameter int WINDOW_SIZE = smb_pkg::WINDOW_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [smb_pkg::REQ_TDATA_W-1:0] req_tdata,  // [31:0] block_time
   input  logic [smb_pkg::REQ_TUSER_W-1:0] req_tuser,  // [0] chain_start
   // Result channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [smb_pkg::RSP_TDATA_W-1:0] rsp_tdata   // [31:0] median_time,
                                                       // [35:32] times_used,
                                                       // [39:36] zero
);

   localparam int IDX_W     = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int CNT_W     = $clog2(WINDOW_SIZE + 1);
   localparam int STEP_W    = (WINDOW_SIZE > 2) ? $clog2(WINDOW_SIZE) : 1;
   localparam int LAST_STEP = (WINDOW_SIZE > 1) ? WINDOW_SIZE - 2 : 0;
   localparam int TW        = smb_pkg::TIME_W;

   // Sequencer state.
   smb_pkg::state_type      state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]           rsp_time_ff;
   logic [smb_pkg::USED_W-1:0] rsp_used_ff;

   smb_pkg::cell_ctrl_type  ctrl;
   logic                    accept;
   logic                    chain_start;
   logic                    load_rsp;

   // Cell chain signals.
   logic [TW-1:0]           cell_time  [WINDOW_SIZE];
   logic [TW-1:0]           time_next  [WINDOW_SIZE];
   logic [TW-1:0]           probe_time [WINDOW_SIZE];
   logic [IDX_W-1:0]        probe_idx  [WINDOW_SIZE];
   logic [CNT_W-1:0]        rank       [WINDOW_SIZE];

   logic [TW-1:0]           median;
   logic [CNT_W+smb_pkg::USED_W-1:0] fill_ext;

   assign req_tready  = (state_ff == smb_pkg::ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign chain_start = req_tuser[0];

   // Cells are kept in age order: cell 0 holds the newest time, so a cell is
   // live exactly when its index is below the fill count.
   genvar g;
   generate
      for (g = 0; g < WINDOW_SIZE; g++) begin : g_cell
         localparam int LEFT = (g + WINDOW_SIZE - 1) % WINDOW_SIZE;
         logic [TW-1:0] time_in;

         if (g == 0) begin : g_head
            assign time_in = req_tdata[TW-1:0];
         end else begin : g_body
            assign time_in = cell_time[g-1];
         end

         smb_cell #(
            .WINDOW_SIZE (WINDOW_SIZE)
         ) u_cell (
            .clock           (clock),
            .ctrl            (ctrl),
            .cell_idx        (IDX_W'(g)),
            .left_idx        (IDX_W'(LEFT)),
            .fill            (fill_ff),
            .time_in         (time_in),
            .left_time_next  (time_next[LEFT]),
            .left_probe_time (probe_time[LEFT]),
            .left_probe_idx  (probe_idx[LEFT]),
            .cell_time       (cell_time[g]),
            .time_next       (time_next[g]),
            .probe_time      (probe_time[g]),
            .probe_idx       (probe_idx[g]),
            .rank            (rank[g])
         );
      end
   endgenerate

   // Exactly one live cell carries the rank fill/2, which is the upper
   // median of the sorted window.
   always_comb begin
      median = '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         if ((CNT_W'(i) < fill_ff) && (rank[i] == (fill_ff >> 1))) begin
            median = median | cell_time[i];
         end
      end
   end

   // Next state and cell control.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      fill_in      = fill_ff;
      ctrl.insert  = 1'b0;
      ctrl.step    = 1'b0;
      load_rsp     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         smb_pkg::ST_IDLE: begin
            if (accept) begin
               ctrl.insert = 1'b1;
               step_in     = '0;
               if (chain_start) begin
                  fill_in = CNT_W'(1);
               end else if (fill_ff != CNT_W'(WINDOW_SIZE)) begin
                  fill_in = fill_ff + CNT_W'(1);
               end
               state_in = (WINDOW_SIZE > 1) ? smb_pkg::ST_RANK : smb_pkg::ST_PICK;
            end
         end
         smb_pkg::ST_RANK: begin
            ctrl.step = 1'b1;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(LAST_STEP)) begin
               state_in = smb_pkg::ST_PICK;
            end
         end
         smb_pkg::ST_PICK: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = smb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smb_pkg::ST_IDLE;
         step_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The reported count is the fill count reduced to the field width.
   assign fill_ext = (CNT_W + smb_pkg::USED_W)'(fill_ff);

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_time_ff <= median;
         rsp_used_ff <= fill_ext[smb_pkg::USED_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_used_ff, rsp_time_ff};

endmodule

FILE: rtl/smb_cell.sv
`timescale 1ns / 1ps

// One window cell: holds one stored time, a travelling probe and the rank of
// its own time among the live entries.
module smb_cell #(
   parameter int  WINDOW_SIZE = smb_pkg::WINDOW_SIZE_DEF,
   localparam int IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1,
   localparam int CNT_W       = $clog2(WINDOW_SIZE + 1)
) (
   input  logic                              clock,
   input  smb_pkg::cell_ctrl_type            ctrl,
   input  logic [IDX_W-1:0]                  cell_idx,
   input  logic [IDX_W-1:0]                  left_idx,
   input  logic [CNT_W-1:0]                  fill,
   input  logic [smb_pkg::TIME_W-1:0]        time_in,
   input  logic [smb_pkg::TIME_W-1:0]        left_time_next,
   input  logic [smb_pkg::TIME_W-1:0]        left_probe_time,
   input  logic [IDX_W-1:0]                  left_probe_idx,
   output logic [smb_pkg::TIME_W-1:0]        cell_time,
   output logic [smb_pkg::TIME_W-1:0]        time_next,
   output logic [smb_pkg::TIME_W-1:0]        probe_time,
   output logic [IDX_W-1:0]                  probe_idx,
   output logic [CNT_W-1:0]                  rank
);

   logic [smb_pkg::TIME_W-1:0] time_ff;
   logic [smb_pkg::TIME_W-1:0] probe_time_ff;
   logic [IDX_W-1:0]           probe_idx_ff;
   logic [CNT_W-1:0]           rank_ff;
   logic                       probe_live;
   logic                       hit;

   assign time_next  = ctrl.insert ? time_in : time_ff;
   assign probe_live = CNT_W'(probe_idx_ff) < fill;

   // The probe counts against us if it is smaller, or equal and younger in
   // the window, so that every live entry ends with a distinct rank.
   assign hit = probe_live &&
                ((probe_time_ff < time_ff) ||
                 ((probe_time_ff == time_ff) && (probe_idx_ff < cell_idx)));

   always_ff @(posedge clock) begin
      if (ctrl.insert) begin
         time_ff       <= time_in;
         probe_time_ff <= left_time_next;
         probe_idx_ff  <= left_idx;
         rank_ff       <= '0;
      end else if (ctrl.step) begin
         probe_time_ff <= left_probe_time;
         probe_idx_ff  <= left_probe_idx;
         rank_ff       <= rank_ff + CNT_W'(hit);
      end
   end

   assign cell_time  = time_ff;
   assign probe_time = probe_time_ff;
   assign probe_idx  = probe_idx_ff;
   assign rank       = rank_ff;

endmodule

FILE: rtl/smb_checker.sv
`timescale 1ns / 1ps

module smb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [smb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // One request is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted during a pass");

   // A result always counts at least the newest time.
   a_used_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[35:32] != 4'd0)
      else $error("result with empty window");

   // The result follows a request: no result appears while the block idles.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && req_tready && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result without a request");

endmodule

bind sliding_median_of_block_times smb_checker u_smb_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

// Keeps its own copy of the eleven-entry timestamp ring and works out the
// median that each request should produce. Results are held in order of
// arrival and matched one by one against the block's responses.
class median_scoreboard;

   typedef struct {
      logic [smb_pkg::TIME_W-1:0] median;
      logic [smb_pkg::USED_W-1:0] used;
   } window_result_type;

   logic [smb_pkg::TIME_W-1:0] ring [smb_pkg::WINDOW_SIZE_DEF];
   int                         fill;
   int                         oldest;
   window_result_type          awaited_medians [$];
   int                         errors;

   function new();
      fill   = 0;
      oldest = 0;
      errors = 0;
   endfunction

   // Apply one accepted request to the ring and queue the median it implies.
   function void note_block(logic [smb_pkg::TIME_W-1:0] block_time, logic chain_start);
      logic [smb_pkg::TIME_W-1:0] sorted [smb_pkg::WINDOW_SIZE_DEF];
      logic [smb_pkg::TIME_W-1:0] v;
      window_result_type          r;
      int                         i;
      int                         j;
      if (chain_start) begin
         fill   = 0;
         oldest = 0;
      end
      if (fill < smb_pkg::WINDOW_SIZE_DEF) begin
         ring[(oldest + fill) % smb_pkg::WINDOW_SIZE_DEF] = block_time;
         fill++;
      end else begin
         ring[oldest] = block_time;
         oldest = (oldest + 1) % smb_pkg::WINDOW_SIZE_DEF;
      end
      for (i = 0; i < fill; i++)
         sorted[i] = ring[(oldest + i) % smb_pkg::WINDOW_SIZE_DEF];
      for (i = 1; i < fill; i++) begin
         v = sorted[i];
         j = i;
         while (j > 0 && sorted[j - 1] > v) begin
            sorted[j] = sorted[j - 1];
            j--;
         end
         sorted[j] = v;
      end
      r.median = sorted[fill / 2];
      r.used   = smb_pkg::USED_W'(fill);
      awaited_medians.insert(awaited_medians.size(), r);
   endfunction

   function void check_median(logic [smb_pkg::RSP_TDATA_W-1:0] word);
      window_result_type r;
      if (awaited_medians.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual tdata %h", $time, word);
         errors++;
         return;
      end
      r = awaited_medians.pop_front();
      if (word[31:0] !== r.median) begin
         $display("%0t: median_time mismatch, expected %h, actual %h",
                  $time, r.median, word[31:0]);
         errors++;
      end
      if (word[35:32] !== r.used) begin
         $display("%0t: times_used mismatch, expected %0d, actual %0d",
                  $time, r.used, word[35:32]);
         errors++;
      end
      if (word[39:36] !== 4'h0) begin
         $display("%0t: pad bits mismatch, expected 0, actual %h", $time, word[39:36]);
         errors++;
      end
   endfunction

endclass

module tb;

   // Requests in the random part, and the cycles without any handshake after
   // which the run is declared hung. The limit is far above the longest
   // correct quiet stretch, which is the receiver's long hold-off below.
   localparam int RANDOM_BLOCKS  = 1850;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_OFF       = 300;
   localparam int HOLD_AT_RESULT = 400;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [smb_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [smb_pkg::REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [smb_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   median_scoreboard board = new();
   int               blocks_sent    = 0;
   int               medians_seen   = 0;
   int               quiet_cycles   = 0;

   sliding_median_of_block_times DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offer one block timestamp and wait for the block to take it. The task
   // is entered just after a rising edge. Handshake signals are read right
   // after the edge, before any nonblocking update of that edge lands, so
   // they show the values that the edge itself sampled. The sender keeps
   // valid high between back-to-back requests and only lowers it when a gap
   // is drawn, so valid never gets two assignments in one step.
   task automatic send_block(input logic [smb_pkg::TIME_W-1:0] block_time,
                             input logic chain_start);
      int gap;
      // Every third stretch of sixty requests is sent without gaps.
      gap = ((blocks_sent / 60) % 3 == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= block_time;
      req_tuser[0] <= chain_start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_block(block_time, chain_start);
      blocks_sent++;
   endtask

   // Draw one timestamp in the style of the current chain: fully random,
   // a realistic rising clock with jitter, a tiny range full of ties, or
   // values pressed against the top of the range.
   function automatic logic [smb_pkg::TIME_W-1:0] next_time(
      input int style,
      inout logic [smb_pkg::TIME_W-1:0] clock_now);
      logic [smb_pkg::TIME_W-1:0] t;
      case (style)
         0: begin
            t = $urandom;
         end
         1: begin
            clock_now = clock_now + $urandom_range(0, 120);
            t = clock_now - $urandom_range(0, 90);
         end
         2: begin
            t = $urandom_range(0, 3);
         end
         default: begin
            t = 32'hFFFF_FFFF - $urandom_range(0, 15);
         end
      endcase
      return t;
   endfunction

   // Receiver. It draws a wait before each result, runs every fourth stretch
   // of fifty results without waits, and once holds off for a long stretch
   // while the sender keeps offering, so the block backs up and stalls its
   // request side.
   initial begin
      int gap;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (medians_seen == HOLD_AT_RESULT)
            gap = HOLD_OFF;
         else if ((medians_seen / 50) % 4 == 0)
            gap = 0;
         else
            gap = $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_median(rsp_tdata);
         medians_seen++;
      end
   end

   // Watchdog: any handshake on either side counts as progress.
   initial begin
      wait (reset == 1'b0);
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Main sequence: reset, a directed opening, long random chains, drain.
   initial begin
      logic [smb_pkg::TIME_W-1:0] clock_now;
      logic [smb_pkg::TIME_W-1:0] t;
      int                         style;
      int                         chain_len;
      int                         k;
      int                         random_sent;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first request after reset carries no start flag; the block must
      // open a fresh window anyway. The next two hit both ends of the range
      // and give an even count, where the upper median is taken.
      send_block(32'd5, 1'b0);
      send_block(32'hFFFF_FFFF, 1'b0);
      send_block(32'h0000_0000, 1'b0);
      // Equal timestamps.
      send_block(32'd7, 1'b0);
      send_block(32'd7, 1'b0);
      send_block(32'd7, 1'b0);
      // Falling times carry the window past full, so the oldest entries are
      // overwritten and the ring wraps.
      for (k = 0; k < 10; k++)
         send_block(32'h8000_0000 - 32'(k * 3), 1'b0);
      // Restarts with the extremes, one right after another.
      send_block(32'hFFFF_FFFF, 1'b1);
      send_block(32'h0000_0000, 1'b1);
      send_block(32'h5555_5555, 1'b0);
      send_block(32'hAAAA_AAAA, 1'b0);

      // Random chains. Most start with the flag and run long enough to fill
      // and wrap the window; some carry on from the previous chain without
      // it, and a few restart in the middle.
      random_sent = 0;
      clock_now   = $urandom;
      while (random_sent < RANDOM_BLOCKS) begin
         style     = $urandom_range(0, 9);
         style     = (style < 5) ? 1 : (style < 7) ? 0 : (style < 9) ? 2 : 3;
         chain_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10)
                                                 : $urandom_range(11, 40);
         clock_now = $urandom;
         for (k = 0; k < chain_len && random_sent < RANDOM_BLOCKS; k++) begin
            t = next_time(style, clock_now);
            if (k == 0)
               send_block(t, $urandom_range(0, 9) != 0);
            else
               send_block(t, $urandom_range(0, 24) == 0);
            random_sent++;
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then give the block time to show any stray result.
      while (board.awaited_medians.size() != 0) @(posedge clock);
      repeat (4 * (smb_pkg::WINDOW_SIZE_DEF + 1)) @(posedge clock);

      if (board.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
